// ----- src/iir_df_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the direct-form IIR filter.
package iir_df_pkg;

  // Filter order, clamped to the supported range of one to four.
  localparam int ORDER   = 4;
  localparam int ORD_EFF = (ORDER < 1) ? 1 : ((ORDER > 4) ? 4 : ORDER);
  // The histories always hold four taps, whatever the order.
  localparam int TAPS    = 4;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int Y_FRAC     = 16;
  localparam int Y_W        = SAMPLE_W + Y_FRAC;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int HALF_W     = CFG_DATA_W / 2;

  // Arithmetic widths: b*x is Q.28, a*y is Q.44 and is rounded to Q.28.
  localparam int BX_W      = COEF_W + SAMPLE_W;
  localparam int AY_P_W    = COEF_W + Y_W;
  localparam int AY_SHIFT  = 16;
  localparam int AY_W      = AY_P_W - AY_SHIFT;
  localparam int TERM_W    = ((BX_W > AY_W) ? BX_W : AY_W) + 1;
  localparam int ACC_W     = TERM_W + 3;
  localparam int ACC_SHIFT = 12;
  localparam int ACC_RND_W = ACC_W - ACC_SHIFT;

  localparam logic signed [AY_P_W-1:0] AY_HALF  = AY_P_W'(1 << (AY_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1 << (ACC_SHIFT - 1));
  localparam logic signed [Y_W:0]      Y_HALF   = (Y_W + 1)'(1 << (Y_FRAC - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [Y_W-1:0]      yq_t;
  typedef logic signed [BX_W-1:0]     bx_t;
  typedef logic signed [AY_P_W-1:0]   ay_prod_t;
  typedef logic signed [AY_W-1:0]     ay_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0_B1 = 3'd0,
    REG_B2_B3 = 3'd1,
    REG_B4_A1 = 3'd2,
    REG_A2_A3 = 3'd3,
    REG_A4    = 3'd4
  } cfg_reg_e;

  // Control that the top level hands to each tap cell.
  typedef struct packed {
    logic  push;
    coef_t coef_b;
    coef_t coef_a;
  } cell_ctrl_t;

  // Round a Q.44 feedback product to Q.28 (add one half, floor shift).
  function automatic ay_t round_product(input ay_prod_t p);
    ay_prod_t r;
    r = p + AY_HALF;
    return AY_W'(r >>> AY_SHIFT);
  endfunction

  // Round the Q.28 accumulator to Q16.16 and saturate to 32 bits.
  function automatic yq_t round_acc_sat(input acc_t acc);
    acc_t                         r;
    logic signed [ACC_RND_W-1:0] s;
    r = acc + ACC_HALF;
    s = ACC_RND_W'(r >>> ACC_SHIFT);
    if (!s[ACC_RND_W-1] && (|s[ACC_RND_W-2:Y_W-1])) begin
      return {1'b0, {(Y_W-1){1'b1}}};
    end else if (s[ACC_RND_W-1] && !(&s[ACC_RND_W-2:Y_W-1])) begin
      return {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      return s[Y_W-1:0];
    end
  endfunction

  // Round a Q16.16 output to an integer sample and saturate to 16 bits.
  function automatic sample_t y_to_sample(input yq_t y);
    logic signed [Y_W:0]        r;
    logic signed [SAMPLE_W:0]   s;
    r = (Y_W + 1)'(y) + Y_HALF;
    s = (SAMPLE_W + 1)'(r >>> Y_FRAC);
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      return s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      return s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ----- src/iir_df_in_if.sv -----
`timescale 1ns / 1ps
// Input sample channel: valid/ready handshake carrying one sample.
interface iir_df_in_if;
  logic                 valid;
  logic                 ready;
  iir_df_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- src/iir_df_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the filtered sample.
interface iir_df_out_if;
  logic                 valid;
  logic                 ready;
  iir_df_pkg::sample_t  filtered;
  logic                 passed_through;

  modport source (output valid, output filtered, output passed_through, input ready);
  modport sink (input valid, input filtered, input passed_through, output ready);
endinterface

// ----- src/iir_df_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
interface iir_df_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [iir_df_pkg::CFG_IDX_W-1:0]      index;
  logic [iir_df_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/iir_df_cell.sv -----
`timescale 1ns / 1ps
// One filter tap: holds an input and an output history entry and its product term.
module iir_df_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  iir_df_pkg::cell_ctrl_t  ctrl_i,
  input  iir_df_pkg::sample_t     x_i,
  input  iir_df_pkg::yq_t         y_i,
  output iir_df_pkg::sample_t     x_o,
  output iir_df_pkg::yq_t         y_o,
  output iir_df_pkg::term_t       term_o
);

  iir_df_pkg::sample_t   x_q, x_d;
  iir_df_pkg::yq_t       y_q, y_d;
  iir_df_pkg::term_t     term_q, term_d;
  iir_df_pkg::coef_t     coef_b;
  iir_df_pkg::coef_t     coef_a;
  iir_df_pkg::bx_t       bx;
  iir_df_pkg::ay_prod_t  ay_prod;
  iir_df_pkg::ay_t       ay;

  // Take the neighbor's entries on a request, then form this tap's term for
  // the next sample from the updated history.
  always_comb begin
    coef_b  = ctrl_i.coef_b;
    coef_a  = ctrl_i.coef_a;
    x_d     = ctrl_i.push ? x_i : x_q;
    y_d     = ctrl_i.push ? y_i : y_q;
    bx      = coef_b * x_d;
    ay_prod = coef_a * y_d;
    ay      = iir_df_pkg::round_product(ay_prod);
    term_d  = iir_df_pkg::TERM_W'(bx) - iir_df_pkg::TERM_W'(ay);
  end

  // History entries and the registered term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      term_q <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      term_q <= term_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign term_o = term_q;

endmodule

// ----- src/iir_direct_form_filter_top.sv -----
`timescale 1ns / 1ps
// Top level of the fourth-order direct-form IIR filter.
//
// The filter takes one sample per clock unless a coefficient write or a
// stalled result channel holds it back. b0*x is formed as the sample is
// accepted and registered with it in the front stage; when the front stage
// advances, the sum stage sums the tap terms, rounds, saturates and loads
// the output register. A row of four tap cells holds the input and output
// histories; each cell keeps its b*x - a*y term registered for the coming
// sample, so the rate is set by the loop from the newest output through
// the first cell's a1 multiplier back into the sum. When the oldest held
// input is zero the sample passes through unchanged and passed_through is
// set. Coefficient writes are always taken; the input channel is not ready
// in a cycle that carries a write, and there is no clearing pass after reset.
module iir_direct_form_filter_top (
  input logic           clk_i,
  input logic           rst_ni,
  iir_df_in_if.sink     in_ch_i,
  iir_df_out_if.source  out_ch_o,
  iir_df_cfg_if.sink    cfg_ch_i
);

  localparam int TAPS = iir_df_pkg::TAPS;
  localparam int HW   = iir_df_pkg::HALF_W;

  // Coefficient registers.
  logic [iir_df_pkg::CFG_DATA_W-1:0] b0_b1_q, b2_b3_q, b4_a1_q, a2_a3_q;
  iir_df_pkg::coef_t                 a4_q;
  logic                              cfg_fire;

  iir_df_pkg::coef_t coef_b [TAPS+1];
  iir_df_pkg::coef_t coef_a [TAPS];

  // Front stage.
  logic                 a_valid_q;
  iir_df_pkg::sample_t  a_x_q;
  iir_df_pkg::bx_t      a_bx0_q, bx0_d;
  logic                 in_fire;
  logic                 b_advance;

  // Sum stage and output register.
  iir_df_pkg::acc_t     acc;
  logic                 pass;
  iir_df_pkg::yq_t      y_new;
  logic                 out_valid_q;
  iir_df_pkg::sample_t  filtered_q;
  logic                 passed_q;

  // Cell chain.
  iir_df_pkg::cell_ctrl_t cell_ctrl [TAPS];
  iir_df_pkg::sample_t    cell_x    [TAPS];
  iir_df_pkg::yq_t        cell_y    [TAPS];
  iir_df_pkg::term_t      cell_term [TAPS];

  // Configuration writes; indexes past the list are ignored.
  assign cfg_ch_i.ready = 1'b1;
  assign cfg_fire       = cfg_ch_i.valid && cfg_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_b1_q <= '0;
      b2_b3_q <= '0;
      b4_a1_q <= '0;
      a2_a3_q <= '0;
      a4_q    <= '0;
    end else if (cfg_fire) begin
      case (iir_df_pkg::cfg_reg_e'(cfg_ch_i.index))
        iir_df_pkg::REG_B0_B1: b0_b1_q <= cfg_ch_i.data;
        iir_df_pkg::REG_B2_B3: b2_b3_q <= cfg_ch_i.data;
        iir_df_pkg::REG_B4_A1: b4_a1_q <= cfg_ch_i.data;
        iir_df_pkg::REG_A2_A3: a2_a3_q <= cfg_ch_i.data;
        iir_df_pkg::REG_A4:    a4_q    <= cfg_ch_i.data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Split the registers into signed coefficients; coef_a[i] is a(i+1).
  assign coef_b[0] = b0_b1_q[2*HW-1:HW];
  assign coef_b[1] = b0_b1_q[HW-1:0];
  assign coef_b[2] = b2_b3_q[2*HW-1:HW];
  assign coef_b[3] = b2_b3_q[HW-1:0];
  assign coef_b[4] = b4_a1_q[2*HW-1:HW];
  assign coef_a[0] = b4_a1_q[HW-1:0];
  assign coef_a[1] = a2_a3_q[2*HW-1:HW];
  assign coef_a[2] = a2_a3_q[HW-1:0];
  assign coef_a[3] = a4_q;

  // Handshake: the front stage refills as soon as the sum stage drains it, unless a coefficient write is pending.
  assign b_advance       = a_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready   = (!a_valid_q || b_advance) && !cfg_ch_i.valid;
  assign in_fire         = in_ch_i.valid && in_ch_i.ready;
  assign bx0_d           = coef_b[0] * in_ch_i.sample;

  // Front stage holds the sample and its b0 product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_x_q     <= '0;
      a_bx0_q   <= '0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
        a_x_q     <= in_ch_i.sample;
        a_bx0_q   <= bx0_d;
      end else if (b_advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  // Sum the b0 product with the terms of the active taps.
  always_comb begin
    acc = iir_df_pkg::ACC_W'(a_bx0_q);
    for (int i = 0; i < TAPS; i++) begin
      if (i < iir_df_pkg::ORD_EFF) begin
        acc = acc + iir_df_pkg::ACC_W'(cell_term[i]);
      end
    end
  end

  // Warm-up rule: a zero oldest input lets the sample through unchanged.
  assign pass  = (cell_x[iir_df_pkg::ORD_EFF-1] == '0);
  assign y_new = pass ? iir_df_pkg::yq_t'({a_x_q, {iir_df_pkg::Y_FRAC{1'b0}}})
                      : iir_df_pkg::round_acc_sat(acc);

  // Output register parts the sum stage from the result channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
      passed_q    <= 1'b0;
    end else begin
      if (b_advance) begin
        out_valid_q <= 1'b1;
        filtered_q  <= iir_df_pkg::y_to_sample(y_new);
        passed_q    <= pass;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.filtered       = filtered_q;
  assign out_ch_o.passed_through = passed_q;

  // Row of tap cells; the first takes the new sample and output.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign cell_ctrl[k].push   = b_advance;
    assign cell_ctrl[k].coef_b = coef_b[k+1];
    assign cell_ctrl[k].coef_a = coef_a[k];

    if (k == 0) begin : g_head
      iir_df_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl[k]),
        .x_i    (a_x_q),
        .y_i    (y_new),
        .x_o    (cell_x[k]),
        .y_o    (cell_y[k]),
        .term_o (cell_term[k])
      );
    end else begin : g_body
      iir_df_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl[k]),
        .x_i    (cell_x[k-1]),
        .y_i    (cell_y[k-1]),
        .x_o    (cell_x[k]),
        .y_o    (cell_y[k]),
        .term_o (cell_term[k])
      );
    end
  end

  // The pending result always matches the newest stored output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> filtered_q == iir_df_pkg::y_to_sample(cell_y[0]))
    else $error("pending result differs from newest output history entry");

  // A passed-through result equals the newest stored input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && passed_q |-> filtered_q == cell_x[0])
    else $error("passed-through result differs from newest input");

  // Each request moves both histories one cell down the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_advance |=> cell_x[1] == $past(cell_x[0]) && cell_y[1] == $past(cell_y[0]))
    else $error("history did not shift along the cell row");

endmodule

// ----- test/iir_direct_form_filter_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the direct-form IIR filter top level.
module iir_direct_form_filter_top_tb;

  localparam int    PIPE_LAT      = 2;
  localparam int    QUIET_LIMIT   = 2000;
  localparam int    REG_COUNT     = 5;
  localparam int    MAX_REPORTS   = 10;
  localparam int    LOWPASS_ITEMS = 600;
  localparam int    RAND_SETTINGS = 5;
  localparam int    RAND_ITEMS    = 160;
  localparam int    SAMPLE_MAX    = 32767;
  localparam int    SAMPLE_MIN    = -32768;
  localparam longint Y_MAX        = (longint'(1) <<< (iir_df_pkg::Y_W - 1)) - 1;
  localparam longint Y_MIN        = -(longint'(1) <<< (iir_df_pkg::Y_W - 1));

  // Q4.28 constants.
  localparam iir_df_pkg::coef_t COEF_ONE = iir_df_pkg::coef_t'(1) <<< 28;
  localparam iir_df_pkg::coef_t COEF_MAX = {1'b0, {(iir_df_pkg::COEF_W-1){1'b1}}};
  localparam iir_df_pkg::coef_t COEF_MIN = {1'b1, {(iir_df_pkg::COEF_W-1){1'b0}}};

  // Fourth-order Butterworth low pass, cutoff at one tenth of the sample rate.
  localparam iir_df_pkg::coef_t LP_B0 = 32'sd111830;
  localparam iir_df_pkg::coef_t LP_B1 = 32'sd447321;
  localparam iir_df_pkg::coef_t LP_B2 = 32'sd670982;
  localparam iir_df_pkg::coef_t LP_A1 = -32'sd853796146;
  localparam iir_df_pkg::coef_t LP_A2 = 32'sd1036481453;
  localparam iir_df_pkg::coef_t LP_A3 = -32'sd566977371;
  localparam iir_df_pkg::coef_t LP_A4 = 32'sd117645891;

  typedef struct packed {
    iir_df_pkg::sample_t filtered;
    logic                passed_through;
  } filter_out_t;

  typedef enum int {
    SEG_STEP,
    SEG_RAMP,
    SEG_WALK,
    SEG_SQUARE,
    SEG_IMPULSE,
    SEG_NOISE
  } seg_shape_e;

  logic clk;
  logic rst_n;

  iir_df_in_if  in_ch ();
  iir_df_out_if out_ch ();
  iir_df_cfg_if cfg_ch ();

  iir_direct_form_filter_top i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  // Filter state as the testbench tracks it.
  logic [iir_df_pkg::CFG_DATA_W-1:0] coef_regs [REG_COUNT];
  iir_df_pkg::sample_t               x_hist [iir_df_pkg::TAPS];
  iir_df_pkg::yq_t                   y_hist [iir_df_pkg::TAPS];
  filter_out_t                       pending_outputs [$];

  int  samples_sent;
  int  results_seen;
  int  warmup_results;
  int  regs_written;
  int  mismatches;
  bit  steady_flow;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Number of idle cycles before the next request on either side.
  function automatic int idle_cycles();
    return steady_flow ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic iir_df_pkg::sample_t clip_sample(input int v);
    if (v > SAMPLE_MAX) return iir_df_pkg::sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return iir_df_pkg::sample_t'(SAMPLE_MIN);
    return iir_df_pkg::sample_t'(v);
  endfunction

  function automatic longint clamp64(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Add one half, then floor shift.
  function automatic longint round_floor(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic iir_df_pkg::coef_t hi_coef(input iir_df_pkg::cfg_reg_e r);
    return iir_df_pkg::coef_t'(coef_regs[r][iir_df_pkg::CFG_DATA_W-1:iir_df_pkg::HALF_W]);
  endfunction

  function automatic iir_df_pkg::coef_t lo_coef(input iir_df_pkg::cfg_reg_e r);
    return iir_df_pkg::coef_t'(coef_regs[r][iir_df_pkg::HALF_W-1:0]);
  endfunction

  function automatic iir_df_pkg::coef_t tap_b(input int i);
    case (i)
      0:       return hi_coef(iir_df_pkg::REG_B0_B1);
      1:       return lo_coef(iir_df_pkg::REG_B0_B1);
      2:       return hi_coef(iir_df_pkg::REG_B2_B3);
      3:       return lo_coef(iir_df_pkg::REG_B2_B3);
      default: return hi_coef(iir_df_pkg::REG_B4_A1);
    endcase
  endfunction

  function automatic iir_df_pkg::coef_t tap_a(input int i);
    case (i)
      1:       return lo_coef(iir_df_pkg::REG_B4_A1);
      2:       return hi_coef(iir_df_pkg::REG_A2_A3);
      3:       return lo_coef(iir_df_pkg::REG_A2_A3);
      default: return lo_coef(iir_df_pkg::REG_A4);
    endcase
  endfunction

  // Compute the result for one sample and advance both histories.
  function automatic filter_out_t predict_filtered(input iir_df_pkg::sample_t x);
    filter_out_t res;
    longint      acc;
    longint      y_next;
    int          i;
    res.passed_through = (x_hist[iir_df_pkg::ORD_EFF-1] == 0);
    if (res.passed_through) begin
      y_next = longint'(x) <<< iir_df_pkg::Y_FRAC;
    end else begin
      acc = longint'(tap_b(0)) * longint'(x);
      for (i = 1; i <= iir_df_pkg::ORD_EFF; i++) begin
        acc += longint'(tap_b(i)) * longint'(x_hist[i-1]);
        acc -= round_floor(longint'(tap_a(i)) * longint'(y_hist[i-1]),
                           iir_df_pkg::AY_SHIFT);
      end
      y_next = clamp64(round_floor(acc, iir_df_pkg::ACC_SHIFT), Y_MIN, Y_MAX);
    end
    for (i = iir_df_pkg::TAPS - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x;
    y_hist[0] = iir_df_pkg::yq_t'(y_next);
    res.filtered = iir_df_pkg::sample_t'(clamp64(round_floor(y_next, iir_df_pkg::Y_FRAC),
                                                 SAMPLE_MIN, SAMPLE_MAX));
    return res;
  endfunction

  // Send one sample and queue its expected result once the request is taken.
  task automatic send_sample(input iir_df_pkg::sample_t s);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid  = 1'b0;
      in_ch.sample = iir_df_pkg::sample_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = s;
    do @(posedge clk); while (!in_ch.ready);
    pending_outputs.push_back(predict_filtered(s));
    samples_sent++;
  endtask

  // Write one register; indexes past the list must leave the filter unchanged.
  task automatic write_reg(input logic [iir_df_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iir_df_pkg::CFG_DATA_W-1:0] data);
    repeat (idle_cycles()) @(negedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < REG_COUNT) begin
      if (idx == iir_df_pkg::REG_A4) begin
        coef_regs[idx] = {{iir_df_pkg::HALF_W{1'b0}}, data[iir_df_pkg::HALF_W-1:0]};
      end else begin
        coef_regs[idx] = data;
      end
    end
    regs_written++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = {$urandom, $urandom};
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_all_coefs(input iir_df_pkg::coef_t b0, input iir_df_pkg::coef_t b1,
                                 input iir_df_pkg::coef_t b2, input iir_df_pkg::coef_t b3,
                                 input iir_df_pkg::coef_t b4, input iir_df_pkg::coef_t a1,
                                 input iir_df_pkg::coef_t a2, input iir_df_pkg::coef_t a3,
                                 input iir_df_pkg::coef_t a4);
    write_reg(iir_df_pkg::REG_B0_B1, {b0, b1});
    write_reg(iir_df_pkg::REG_B2_B3, {b2, b3});
    write_reg(iir_df_pkg::REG_B4_A1, {b4, a1});
    write_reg(iir_df_pkg::REG_A2_A3, {a2, a3});
    // The upper half of the last register carries junk that must be dropped.
    write_reg(iir_df_pkg::REG_A4, {iir_df_pkg::coef_t'($urandom), a4});
  endtask

  function automatic iir_df_pkg::sample_t noise_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return iir_df_pkg::sample_t'(SAMPLE_MIN);
      2:       return iir_df_pkg::sample_t'(SAMPLE_MAX);
      default: return iir_df_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic iir_df_pkg::coef_t rand_coef(input int shift);
    iir_df_pkg::coef_t c;
    c = iir_df_pkg::coef_t'($urandom);
    return c >>> shift;
  endfunction

  // Play one run of a signal shape with random content.
  task automatic play_segment(input int len);
    seg_shape_e shape;
    int         level;
    int         slope;
    int         period;
    int         delta;
    int         k;
    shape  = seg_shape_e'($urandom_range(0, SEG_NOISE));
    level  = iir_df_pkg::sample_t'($urandom);
    if ($urandom_range(0, 7) == 0) level = 0;
    slope  = $urandom_range(0, 2048);
    slope  = slope - 1024;
    period = $urandom_range(1, 8);
    for (k = 0; k < len; k++) begin
      case (shape)
        SEG_STEP:    send_sample(clip_sample(level));
        SEG_RAMP:    send_sample(clip_sample(level + k * slope));
        SEG_WALK: begin
          delta = $urandom_range(0, 512);
          level = clip_sample(level + delta - 256);
          send_sample(iir_df_pkg::sample_t'(level));
        end
        SEG_SQUARE:  send_sample(((k / period) % 2) ? clip_sample(-level) : clip_sample(level));
        SEG_IMPULSE: send_sample((k == 0) ? clip_sample(level) : iir_df_pkg::sample_t'(0));
        default:     send_sample(noise_sample());
      endcase
    end
  endtask

  // With zero coefficients after reset, the first samples bypass the filter.
  task automatic test_warmup_after_reset();
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MIN));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    send_sample(iir_df_pkg::sample_t'(1));
    send_sample(iir_df_pkg::sample_t'(-1));
    send_sample(iir_df_pkg::sample_t'(21845));
    send_sample(iir_df_pkg::sample_t'(-21846));
    send_sample(iir_df_pkg::sample_t'(0));
    send_sample(iir_df_pkg::sample_t'(0));
    send_sample(iir_df_pkg::sample_t'(7));
    send_sample(iir_df_pkg::sample_t'(-7));
    drain();
  endtask

  // Largest and smallest coefficients drive both saturation stages.
  task automatic test_coef_extremes();
    write_all_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                    COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MIN));
    send_sample(iir_df_pkg::sample_t'(0));
    drain();
    write_all_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                    COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MIN));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    send_sample(iir_df_pkg::sample_t'(-1));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MIN));
    drain();
  endtask

  // Writes to indexes past the register list must not disturb an identity filter.
  task automatic test_ignored_index();
    int k;
    write_all_coefs(COEF_ONE, '0, '0, '0, '0, '0, '0, '0, '0);
    for (k = REG_COUNT; k < (1 << iir_df_pkg::CFG_IDX_W); k++) begin
      write_reg(iir_df_pkg::CFG_IDX_W'(k), {iir_df_pkg::CFG_DATA_W{1'b1}});
    end
    send_sample(iir_df_pkg::sample_t'(100));
    send_sample(iir_df_pkg::sample_t'(-100));
    send_sample(iir_df_pkg::sample_t'(SAMPLE_MAX));
    drain();
  endtask

  // Realistic low-pass coefficients fed with shaped signal runs.
  task automatic test_lowpass_streams();
    int start;
    write_all_coefs(LP_B0, LP_B1, LP_B2, LP_B1, LP_B0, LP_A1, LP_A2, LP_A3, LP_A4);
    start = samples_sent;
    while (samples_sent - start < LOWPASS_ITEMS) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      play_segment($urandom_range(8, 40));
    end
    steady_flow = 1'b0;
    drain();
  endtask

  // Random coefficient sets, from full scale down to small magnitudes.
  task automatic test_random_coefs();
    int s;
    int r;
    int shift;
    int start;
    for (s = 0; s < RAND_SETTINGS; s++) begin
      shift = (s == 0) ? 0 : $urandom_range(1, 8);
      for (r = 0; r < REG_COUNT; r++) begin
        write_reg(iir_df_pkg::CFG_IDX_W'(r), {rand_coef(shift), rand_coef(shift)});
      end
      if ($urandom_range(0, 1)) begin
        write_reg(iir_df_pkg::CFG_IDX_W'($urandom_range(REG_COUNT,
                                                        (1 << iir_df_pkg::CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
      end
      start = samples_sent;
      while (samples_sent - start < RAND_ITEMS) begin
        steady_flow = ($urandom_range(0, 4) == 0);
        play_segment($urandom_range(8, 40));
      end
      steady_flow = 1'b0;
      drain();
    end
  endtask

  task automatic report_mismatch(input string field, input int expected, input int actual);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, field, expected, actual);
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    filter_out_t exp_out;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: filtered %0d with nothing pending", out_ch.filtered);
        end
      end else begin
        exp_out = pending_outputs.pop_front();
        results_seen++;
        if (exp_out.passed_through) warmup_results++;
        if (out_ch.filtered !== exp_out.filtered) begin
          report_mismatch("filtered", exp_out.filtered, out_ch.filtered);
        end
        if (out_ch.passed_through !== exp_out.passed_through) begin
          report_mismatch("passed_through", exp_out.passed_through, out_ch.passed_through);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = idle_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  // Watchdog: end the run when no request of any kind is taken for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no request accepted for %0d cycles", QUIET_LIMIT);
    $display("** iir_direct_form_filter_top: FAILED **");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    steady_flow    = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    samples_sent   = 0;
    results_seen   = 0;
    warmup_results = 0;
    regs_written   = 0;
    mismatches     = 0;
    for (int i = 0; i < REG_COUNT; i++) coef_regs[i] = '0;
    for (int i = 0; i < iir_df_pkg::TAPS; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_warmup_after_reset();
    test_coef_extremes();
    test_ignored_index();
    test_lowpass_streams();
    test_random_coefs();

    drain();
    repeat (PIPE_LAT + 2) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_outputs.size());
    end
    $display("Sent %0d samples and %0d register writes; %0d results checked.",
             samples_sent, regs_written, results_seen);
    $display("%0d results took the warm-up bypass; %0d mismatches found.",
             warmup_results, mismatches);
    if (mismatches == 0) begin
      $display("** iir_direct_form_filter_top: PASSED **");
    end else begin
      $display("** iir_direct_form_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/iir_df_pkg.sv
src/iir_df_in_if.sv
src/iir_df_out_if.sv
src/iir_df_cfg_if.sv
src/iir_df_cell.sv
src/iir_direct_form_filter_top.sv
test/iir_direct_form_filter_top_tb.sv
